>>> design/swrf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrf_pkg
// Shared widths, constants and types of the shallow-water Rusanov flux block.
// ----------------------------------------------------------------------------
package swrf_pkg;

    // Default number of fraction bits of all fixed-point values.
    localparam int FRAC_BITS_DEF = 16;

    // Field widths.
    localparam int GW = 25;         // gravity register
    localparam int HW = 31;         // depth
    localparam int VW = 32;         // velocity
    localparam int UW = VW + 1;     // velocity after mirroring (negation cannot wrap)
    localparam int QW = 62;         // signed product result, magnitude clamped to 2^60

    // Latency of one fixed-point product.
    localparam int QLAT = 3;

    // Magnitude clamp of a product, 2^60.
    localparam logic [QW-2:0] QLIMIT = {1'b1, {(QW-2){1'b0}}};

    // Gravity after reset, 9.81 in unsigned Q9.16.
    localparam logic [GW-1:0] GRAVITY_RESET = 25'd642908;

    // Face kinds.
    typedef enum logic [1:0] {
        MODE_INTERIOR   = 2'd0,
        MODE_WALL_LEFT  = 2'd1,
        MODE_WALL_RIGHT = 2'd2
    } mode_t;

    // State on one side of the face.
    typedef struct packed {
        logic        [HW-1:0] h;
        logic signed [UW-1:0] u;
        logic signed [VW-1:0] v;
    } side_t;

    typedef struct packed {
        side_t l;
        side_t r;
    } face_t;

endpackage

>>> design/swrf_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrf channel interfaces
// Face input, flux output and gravity write channels with valid/ready.
// ----------------------------------------------------------------------------

// Face states in.
interface swrf_face_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        mode;
    logic [swrf_pkg::HW-1:0]           depth_left;
    logic signed [swrf_pkg::VW-1:0]    normal_vel_left;
    logic signed [swrf_pkg::VW-1:0]    tangent_vel_left;
    logic [swrf_pkg::HW-1:0]           depth_right;
    logic signed [swrf_pkg::VW-1:0]    normal_vel_right;
    logic signed [swrf_pkg::VW-1:0]    tangent_vel_right;

    modport source (
        output valid, mode, depth_left, normal_vel_left, tangent_vel_left,
               depth_right, normal_vel_right, tangent_vel_right,
        input  ready
    );
    modport sink (
        input  valid, mode, depth_left, normal_vel_left, tangent_vel_left,
               depth_right, normal_vel_right, tangent_vel_right,
        output ready
    );
endinterface

// Fluxes out.
interface swrf_flux_if;
    logic                              valid;
    logic                              ready;
    logic signed [swrf_pkg::VW-1:0]    mass_flux;
    logic signed [swrf_pkg::VW-1:0]    normal_mom_flux;
    logic signed [swrf_pkg::VW-1:0]    tangent_mom_flux;
    logic [swrf_pkg::HW-1:0]           max_wave_speed;
    logic                              saturated;

    modport source (
        output valid, mass_flux, normal_mom_flux, tangent_mom_flux,
               max_wave_speed, saturated,
        input  ready
    );
    modport sink (
        input  valid, mass_flux, normal_mom_flux, tangent_mom_flux,
               max_wave_speed, saturated,
        output ready
    );
endinterface

// Gravity register writes.
interface swrf_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [swrf_pkg::GW-1:0]     gravity;

    modport source (output valid, gravity, input ready);
    modport sink (input valid, gravity, output ready);
endinterface

>>> design/swrf_qmul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrf_qmul
// Three-stage signed fixed-point product: split partial products, sum, then
// round half away from zero, clamp the magnitude to 2^60 and apply the sign.
// ----------------------------------------------------------------------------
module swrf_qmul #(
    parameter int AW        = 32,
    parameter int BW        = 32,
    parameter int FRAC_BITS = swrf_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [AW-1:0]          a,
    input  logic signed [BW-1:0]          b,
    output logic signed [swrf_pkg::QW-1:0] p
);

    localparam int QW = swrf_pkg::QW;
    localparam int LO = AW / 2;
    localparam int HI = AW - LO;
    localparam int PW = AW + BW;
    localparam int RW = (PW + 1 > QW) ? PW + 1 : QW;

    logic [AW-1:0]         a_bits;
    logic [BW-1:0]         b_bits;
    logic [AW-1:0]         mag_a;
    logic [BW-1:0]         mag_b;
    logic [LO+BW-1:0]      plo_reg;
    logic [HI+BW-1:0]      phi_reg;
    logic                  neg1_reg;
    logic [PW-1:0]         prod_reg;
    logic                  neg2_reg;
    logic [RW-1:0]         rnd;
    logic [QW-2:0]         mag_p;
    logic signed [QW-1:0]  mag_s;
    logic signed [QW-1:0]  p_next;
    logic signed [QW-1:0]  p_reg;

    // Magnitudes of the operands.
    assign a_bits = a;
    assign b_bits = b;
    assign mag_a  = a[AW-1] ? (~a_bits + 1'b1) : a_bits;
    assign mag_b  = b[BW-1] ? (~b_bits + 1'b1) : b_bits;

    // Stage 1: two partial products over the halves of the first operand.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            plo_reg  <= mag_a[LO-1:0] * mag_b;
            phi_reg  <= mag_a[AW-1:LO] * mag_b;
            neg1_reg <= a[AW-1] ^ b[BW-1];
        end
    end

    // Stage 2: combine the partial products into the exact product.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= PW'(plo_reg) + (PW'(phi_reg) << LO);
            neg2_reg <= neg1_reg;
        end
    end

    // Stage 3: round, clamp and sign.
    always_comb
    begin
        rnd    = (RW'(prod_reg) + (RW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        mag_p  = (rnd > RW'(swrf_pkg::QLIMIT)) ? swrf_pkg::QLIMIT : rnd[QW-2:0];
        mag_s  = {1'b0, mag_p};
        p_next = neg2_reg ? -mag_s : mag_s;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

>>> design/swrf_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrf_isqrt
// Pipelined integer square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module swrf_isqrt #(
    parameter int XW = 56
) (
    input  logic                      clk,
    input  logic                      en,
    input  logic [XW-1:0]             x,
    output logic [(XW+1)/2-1:0]       root
);

    localparam int RW = (XW + 1) / 2;

    logic [XW-1:0] rem_reg  [RW];
    logic [RW-1:0] root_reg [RW];

    // Each stage decides one root bit, most significant first.
    for (genvar j = 0; j < RW; j++)
    begin : g_step
        localparam int BI = RW - 1 - j;

        logic [XW-1:0] rem_in;
        logic [XW-1:0] trial;
        logic [XW-1:0] rem_next;
        logic [RW-1:0] root_in;
        logic [RW-1:0] root_next;

        if (j == 0)
        begin : g_first
            assign rem_in  = x;
            assign root_in = '0;
        end
        else
        begin : g_later
            assign rem_in  = rem_reg[j-1];
            assign root_in = root_reg[j-1];
        end

        // Setting this bit adds 2*root*2^BI + 2^(2*BI) to the square.
        always_comb
        begin
            trial = (XW'(root_in) << (BI + 1)) | (XW'(1) << (2 * BI));
            if (rem_in >= trial)
            begin
                rem_next  = rem_in - trial;
                root_next = root_in | (RW'(1) << BI);
            end
            else
            begin
                rem_next  = rem_in;
                root_next = root_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j]  <= rem_next;
                root_reg[j] <= root_next;
            end
        end
    end

    assign root = root_reg[RW-1];

endmodule

>>> design/shallow_water_rusanov_flux.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shallow_water_rusanov_flux
// Rusanov flux of the 2D shallow-water equations at one cell face.
// ----------------------------------------------------------------------------
// Usage:
// The face channel takes one transaction per face: a mode and depth, normal
// and tangential velocity on each side. The flux channel returns one
// transaction per face with the mass, normal-momentum and tangential-momentum
// fluxes, the larger wave speed and a flag for clipped fluxes, in order.
// The cfg channel writes gravity; it is always ready. The user must write it
// only while no face is in flight; the block does not enforce this.
// The depth of the pipeline is set by the square root (28 stages, one root
// bit each) followed by two rows of three-stage products. Throughput is one
// face per cycle while the receiver does not stall the flux channel.
// Reset clears all valid bits and loads gravity with 9.81. When the receiver
// stalls with a flux waiting, the whole pipeline holds and face.ready drops;
// nothing is lost or repeated.
// ----------------------------------------------------------------------------
module shallow_water_rusanov_flux #(
    parameter int FRAC_BITS = swrf_pkg::FRAC_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    swrf_face_if.sink     face,
    swrf_flux_if.source   flux,
    swrf_cfg_if.sink      cfg
);

    localparam int GW   = swrf_pkg::GW;
    localparam int HW   = swrf_pkg::HW;
    localparam int VW   = swrf_pkg::VW;
    localparam int UW   = swrf_pkg::UW;
    localparam int QW   = swrf_pkg::QW;
    localparam int QLAT = swrf_pkg::QLAT;
    localparam int XW   = GW + HW;
    localparam int SQW  = (XW + 1) / 2;
    localparam int SUMW = QW + 2;

    // Pipeline positions.
    localparam int P_GH   = 1;
    localparam int P_SQ   = P_GH + SQW;
    localparam int P_S    = P_SQ + 1;
    localparam int P_Q1   = P_S + QLAT;
    localparam int P_Q2   = P_Q1 + QLAT;
    localparam int P_SUM  = P_Q2 + 1;
    localparam int P_OUT  = P_SUM + 1;
    localparam int NSTG   = P_OUT + 1;
    localparam int NSD    = P_Q2 - P_S + 1;

    localparam logic signed [SUMW-1:0] SUM_MAX = {{(SUMW-VW+1){1'b0}}, {(VW-1){1'b1}}};
    localparam logic signed [SUMW-1:0] SUM_MIN = {{(SUMW-VW+1){1'b1}}, {(VW-1){1'b0}}};
    localparam logic signed [VW-1:0]   F_MAX   = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0]   F_MIN   = {1'b1, {(VW-1){1'b0}}};

    typedef struct packed {
        logic signed [QW-1:0] l;
        logic signed [QW-1:0] r;
    } qpair_t;

    // Halving with halves rounded away from zero.
    function automatic logic signed [SUMW-1:0] halve_f(input logic signed [SUMW-1:0] x);
        logic [SUMW-1:0] bits;
        logic [SUMW-1:0] m;
        bits = x;
        m    = x[SUMW-1] ? (~bits + 1'b1) : bits;
        m    = (m + 1'b1) >> 1;
        return x[SUMW-1] ? -$signed(m) : $signed(m);
    endfunction

    logic                  adv;
    logic [NSTG-1:0]       vld_reg;
    logic [GW-1:0]         gravity_reg;

    swrf_pkg::mode_t       mode_sel;
    swrf_pkg::face_t       face_next;
    swrf_pkg::face_t       fd_reg [P_Q1+1];

    logic [XW-1:0]         ghl_reg;
    logic [XW-1:0]         ghr_reg;
    logic [SQW-1:0]        sql;
    logic [SQW-1:0]        sqr;

    logic [UW-1:0]         mag_ul;
    logic [UW-1:0]         mag_ur;
    logic [UW-1:0]         spd_l;
    logic [UW-1:0]         spd_r;
    logic [UW-1:0]         sd_reg [NSD];

    logic signed [QW-1:0]  q_l;
    logic signed [QW-1:0]  q_r;
    logic signed [QW-1:0]  t_l;
    logic signed [QW-1:0]  t_r;
    logic signed [QW-1:0]  gh_l;
    logic signed [QW-1:0]  gh_r;
    qpair_t                qd_reg [QLAT];

    logic signed [UW:0]    s_q1;
    logic signed [HW:0]    dh;
    logic signed [QW:0]    dq;
    logic signed [QW:0]    dt;
    logic signed [QW-1:0]  p_qul;
    logic signed [QW-1:0]  p_qur;
    logic signed [QW-1:0]  p_qvl;
    logic signed [QW-1:0]  p_qvr;
    logic signed [QW-1:0]  p_ghl;
    logic signed [QW-1:0]  p_ghr;
    logic signed [QW-1:0]  p_sh;
    logic signed [QW-1:0]  p_sq;
    logic signed [QW-1:0]  p_st;

    logic signed [SUMW-1:0] fm_reg;
    logic signed [SUMW-1:0] fn_reg;
    logic signed [SUMW-1:0] ft_reg;
    logic [UW-1:0]          ssum_reg;

    logic signed [SUMW-1:0] hm;
    logic signed [SUMW-1:0] hn;
    logic signed [SUMW-1:0] ht;
    logic signed [VW-1:0]   mass_next;
    logic signed [VW-1:0]   norm_next;
    logic signed [VW-1:0]   tang_next;
    logic                   sat_next;
    logic signed [VW-1:0]   mass_reg;
    logic signed [VW-1:0]   norm_reg;
    logic signed [VW-1:0]   tang_reg;
    logic [HW-1:0]          ws_reg;
    logic                   sat_reg;

    // The pipeline moves whenever the output register is free or being taken.
    assign adv        = !vld_reg[P_OUT] || flux.ready;
    assign face.ready = adv;
    assign cfg.ready  = 1'b1;

    // Gravity register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gravity_reg <= swrf_pkg::GRAVITY_RESET;
        end
        else if (cfg.valid)
        begin
            gravity_reg <= cfg.gravity;
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NSTG-2:0], face.valid};
        end
    end

    // Load both sides and apply wall mirroring.
    always_comb
    begin
        mode_sel        = swrf_pkg::mode_t'(face.mode);
        face_next.l.h   = face.depth_left;
        face_next.l.u   = {face.normal_vel_left[VW-1], face.normal_vel_left};
        face_next.l.v   = face.tangent_vel_left;
        face_next.r.h   = face.depth_right;
        face_next.r.u   = {face.normal_vel_right[VW-1], face.normal_vel_right};
        face_next.r.v   = face.tangent_vel_right;
        unique case (mode_sel)
            swrf_pkg::MODE_WALL_LEFT:
            begin
                face_next.r.h = face_next.l.h;
                face_next.r.u = -face_next.l.u;
                face_next.r.v = face_next.l.v;
            end
            swrf_pkg::MODE_WALL_RIGHT:
            begin
                face_next.l.h = face_next.r.h;
                face_next.l.u = -face_next.r.u;
                face_next.l.v = face_next.r.v;
            end
            default:
            begin
            end
        endcase
    end

    // Face state delay line up to the second row of products.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fd_reg[0] <= face_next;
            for (int k = 1; k <= P_Q1; k++)
            begin
                fd_reg[k] <= fd_reg[k-1];
            end
        end
    end

    // Raw g*h for the square roots.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ghl_reg <= XW'(gravity_reg) * XW'(fd_reg[0].l.h);
            ghr_reg <= XW'(gravity_reg) * XW'(fd_reg[0].r.h);
        end
    end

    swrf_isqrt #(.XW(XW)) u_sqrt_l (.clk(clk), .en(adv), .x(ghl_reg), .root(sql));
    swrf_isqrt #(.XW(XW)) u_sqrt_r (.clk(clk), .en(adv), .x(ghr_reg), .root(sqr));

    // Side wave speeds and their maximum.
    always_comb
    begin
        mag_ul = fd_reg[P_SQ].l.u[UW-1] ? UW'(-fd_reg[P_SQ].l.u) : UW'(fd_reg[P_SQ].l.u);
        mag_ur = fd_reg[P_SQ].r.u[UW-1] ? UW'(-fd_reg[P_SQ].r.u) : UW'(fd_reg[P_SQ].r.u);
        spd_l  = mag_ul + UW'(sql);
        spd_r  = mag_ur + UW'(sqr);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sd_reg[0] <= (spd_l > spd_r) ? spd_l : spd_r;
            for (int k = 1; k < NSD; k++)
            begin
                sd_reg[k] <= sd_reg[k-1];
            end
        end
    end

    // First row of products: discharges, tangential transports and g*h.
    swrf_qmul #(.AW(HW+1), .BW(UW), .FRAC_BITS(FRAC_BITS)) u_ql (
        .clk(clk), .en(adv), .a({1'b0, fd_reg[P_S].l.h}), .b(fd_reg[P_S].l.u), .p(q_l));
    swrf_qmul #(.AW(HW+1), .BW(UW), .FRAC_BITS(FRAC_BITS)) u_qr (
        .clk(clk), .en(adv), .a({1'b0, fd_reg[P_S].r.h}), .b(fd_reg[P_S].r.u), .p(q_r));
    swrf_qmul #(.AW(HW+1), .BW(VW), .FRAC_BITS(FRAC_BITS)) u_tl (
        .clk(clk), .en(adv), .a({1'b0, fd_reg[P_S].l.h}), .b(fd_reg[P_S].l.v), .p(t_l));
    swrf_qmul #(.AW(HW+1), .BW(VW), .FRAC_BITS(FRAC_BITS)) u_tr (
        .clk(clk), .en(adv), .a({1'b0, fd_reg[P_S].r.h}), .b(fd_reg[P_S].r.v), .p(t_r));
    swrf_qmul #(.AW(GW+1), .BW(HW+1), .FRAC_BITS(FRAC_BITS)) u_ghl (
        .clk(clk), .en(adv), .a({1'b0, gravity_reg}), .b({1'b0, fd_reg[P_S].l.h}), .p(gh_l));
    swrf_qmul #(.AW(GW+1), .BW(HW+1), .FRAC_BITS(FRAC_BITS)) u_ghr (
        .clk(clk), .en(adv), .a({1'b0, gravity_reg}), .b({1'b0, fd_reg[P_S].r.h}), .p(gh_r));

    // Discharges wait for the second row of products.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            qd_reg[0].l <= q_l;
            qd_reg[0].r <= q_r;
            for (int k = 1; k < QLAT; k++)
            begin
                qd_reg[k] <= qd_reg[k-1];
            end
        end
    end

    // Differences scaled by the wave speed.
    always_comb
    begin
        s_q1 = {1'b0, sd_reg[P_Q1-P_S]};
        dh   = $signed({1'b0, fd_reg[P_Q1].r.h}) - $signed({1'b0, fd_reg[P_Q1].l.h});
        dq   = {q_r[QW-1], q_r} - {q_l[QW-1], q_l};
        dt   = {t_r[QW-1], t_r} - {t_l[QW-1], t_l};
    end

    // Second row of products.
    swrf_qmul #(.AW(QW), .BW(UW), .FRAC_BITS(FRAC_BITS)) u_qul (
        .clk(clk), .en(adv), .a(q_l), .b(fd_reg[P_Q1].l.u), .p(p_qul));
    swrf_qmul #(.AW(QW), .BW(UW), .FRAC_BITS(FRAC_BITS)) u_qur (
        .clk(clk), .en(adv), .a(q_r), .b(fd_reg[P_Q1].r.u), .p(p_qur));
    swrf_qmul #(.AW(QW), .BW(VW), .FRAC_BITS(FRAC_BITS)) u_qvl (
        .clk(clk), .en(adv), .a(q_l), .b(fd_reg[P_Q1].l.v), .p(p_qvl));
    swrf_qmul #(.AW(QW), .BW(VW), .FRAC_BITS(FRAC_BITS)) u_qvr (
        .clk(clk), .en(adv), .a(q_r), .b(fd_reg[P_Q1].r.v), .p(p_qvr));
    swrf_qmul #(.AW(QW), .BW(HW+1), .FRAC_BITS(FRAC_BITS)) u_pghl (
        .clk(clk), .en(adv), .a(gh_l), .b({1'b0, fd_reg[P_Q1].l.h}), .p(p_ghl));
    swrf_qmul #(.AW(QW), .BW(HW+1), .FRAC_BITS(FRAC_BITS)) u_pghr (
        .clk(clk), .en(adv), .a(gh_r), .b({1'b0, fd_reg[P_Q1].r.h}), .p(p_ghr));
    swrf_qmul #(.AW(HW+1), .BW(UW+1), .FRAC_BITS(FRAC_BITS)) u_sh (
        .clk(clk), .en(adv), .a(dh), .b(s_q1), .p(p_sh));
    swrf_qmul #(.AW(QW+1), .BW(UW+1), .FRAC_BITS(FRAC_BITS)) u_sq (
        .clk(clk), .en(adv), .a(dq), .b(s_q1), .p(p_sq));
    swrf_qmul #(.AW(QW+1), .BW(UW+1), .FRAC_BITS(FRAC_BITS)) u_st (
        .clk(clk), .en(adv), .a(dt), .b(s_q1), .p(p_st));

    // Sum the flux terms before the final halving.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fm_reg   <= SUMW'(qd_reg[QLAT-1].l) + SUMW'(qd_reg[QLAT-1].r) - SUMW'(p_sh);
            fn_reg   <= SUMW'(p_qul) + halve_f(SUMW'(p_ghl)) + SUMW'(p_qur)
                        + halve_f(SUMW'(p_ghr)) - SUMW'(p_sq);
            ft_reg   <= SUMW'(p_qvl) + SUMW'(p_qvr) - SUMW'(p_st);
            ssum_reg <= sd_reg[P_Q2-P_S];
        end
    end

    // Halve, saturate and flag clipping.
    always_comb
    begin
        hm = halve_f(fm_reg);
        hn = halve_f(fn_reg);
        ht = halve_f(ft_reg);
        sat_next = 1'b0;
        if (hm > SUM_MAX)
        begin
            mass_next = F_MAX;
            sat_next  = 1'b1;
        end
        else if (hm < SUM_MIN)
        begin
            mass_next = F_MIN;
            sat_next  = 1'b1;
        end
        else
        begin
            mass_next = hm[VW-1:0];
        end
        if (hn > SUM_MAX)
        begin
            norm_next = F_MAX;
            sat_next  = 1'b1;
        end
        else if (hn < SUM_MIN)
        begin
            norm_next = F_MIN;
            sat_next  = 1'b1;
        end
        else
        begin
            norm_next = hn[VW-1:0];
        end
        if (ht > SUM_MAX)
        begin
            tang_next = F_MAX;
            sat_next  = 1'b1;
        end
        else if (ht < SUM_MIN)
        begin
            tang_next = F_MIN;
            sat_next  = 1'b1;
        end
        else
        begin
            tang_next = ht[VW-1:0];
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mass_reg <= mass_next;
            norm_reg <= norm_next;
            tang_reg <= tang_next;
            sat_reg  <= sat_next;
            ws_reg   <= (ssum_reg > UW'({HW{1'b1}})) ? {HW{1'b1}} : ssum_reg[HW-1:0];
        end
    end

    assign flux.valid            = vld_reg[P_OUT];
    assign flux.mass_flux        = mass_reg;
    assign flux.normal_mom_flux  = norm_reg;
    assign flux.tangent_mom_flux = tang_reg;
    assign flux.max_wave_speed   = ws_reg;
    assign flux.saturated        = sat_reg;

`ifndef SYNTHESIS
    // A transaction one stage short of the output lands there when the pipe moves.
    a_last_stage: assert property (@(posedge clk) disable iff (!rst_n)
        adv && vld_reg[P_OUT-1] |=> flux.valid)
        else $error("flux transaction lost in the last stage");

    // A stalled output freezes every valid bit in the pipeline.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        flux.valid && !flux.ready |=> $stable(vld_reg))
        else $error("pipeline moved during an output stall");

    // The clip flag is only raised with some flux at a rail.
    a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
        flux.valid && flux.saturated |->
            (flux.mass_flux == F_MAX || flux.mass_flux == F_MIN ||
             flux.normal_mom_flux == F_MAX || flux.normal_mom_flux == F_MIN ||
             flux.tangent_mom_flux == F_MAX || flux.tangent_mom_flux == F_MIN))
        else $error("saturated set without a clipped flux");

    // Gravity changes only through a cfg transaction.
    a_grav_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(cfg.valid && cfg.ready) |=> $stable(gravity_reg))
        else $error("gravity changed without a write");
`endif

endmodule

>>> verif/shallow_water_rusanov_flux_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shallow_water_rusanov_flux_test
// Drives faces through the Rusanov flux block under random idling on both
// channels, predicts each flux in fixed point and checks every transaction
// in order. Gravity is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module shallow_water_rusanov_flux_test;

    localparam int FB = swrf_pkg::FRAC_BITS_DEF;
    localparam int HW = swrf_pkg::HW;
    localparam int GW = swrf_pkg::GW;
    localparam int DRAIN = 60;
    localparam longint LIMIT = 400000;

    typedef struct packed {
        logic [1:0]         mode;
        logic [HW-1:0]      hl;
        logic signed [31:0] ul;
        logic signed [31:0] vl;
        logic [HW-1:0]      hr;
        logic signed [31:0] ur;
        logic signed [31:0] vr;
    } face_item_t;

    typedef struct packed {
        logic signed [31:0] fm;
        logic signed [31:0] fn;
        logic signed [31:0] ft;
        logic [HW-1:0]      spd;
        logic               sat;
    } flux_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    swrf_face_if face_ch ();
    swrf_flux_if flux_ch ();
    swrf_cfg_if  cfg_ch ();

    shallow_water_rusanov_flux uut (
        .clk   (clk),
        .rst_n (rst_n),
        .face  (face_ch.sink),
        .flux  (flux_ch.source),
        .cfg   (cfg_ch.sink)
    );

    always #1 clk = ~clk;

    face_item_t    face_queue[$];
    flux_item_t    flux_expected[$];
    logic [GW-1:0] grav_model = swrf_pkg::GRAVITY_RESET;
    logic [GW-1:0] grav_pending;
    bit            grav_req = 0;
    bit            calm = 0;
    int            mismatches = 0;
    longint        cycles = 0;

    // Signed fixed-point product, magnitude rounded half away and clamped to 2^60.
    function automatic logic signed [127:0] fx_mul(logic signed [127:0] a,
                                                   logic signed [127:0] b);
        logic [127:0] ma;
        logic [127:0] mb;
        logic [255:0] p;
        logic [255:0] m;
        ma = a < 0 ? -a : a;
        mb = b < 0 ? -b : b;
        p = ma * mb;
        m = (p + (256'd1 << (FB - 1))) >> FB;
        if (m > (256'd1 << 60))
            m = 256'd1 << 60;
        return ((a < 0) != (b < 0)) ? -$signed({1'b0, m[126:0]}) : $signed({1'b0, m[126:0]});
    endfunction

    function automatic logic signed [127:0] halve_away(logic signed [127:0] x);
        logic [127:0] m;
        m = ((x < 0 ? -x : x) + 1) >> 1;
        return x < 0 ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] x);
        logic [63:0] r;
        r = 0;
        for (int i = 31; i >= 0; i--)
            if ((r | (64'd1 << i)) * (r | (64'd1 << i)) <= x)
                r = r | (64'd1 << i);
        return r;
    endfunction

    function automatic logic signed [31:0] clamp_flux(logic signed [127:0] x,
                                                      inout logic sat);
        if (x > 128'sd2147483647)
        begin
            sat = 1;
            return 32'sh7fffffff;
        end
        if (x < -128'sd2147483648)
        begin
            sat = 1;
            return 32'sh80000000;
        end
        return x[31:0];
    endfunction

    // Expected flux of one face under the current gravity.
    function automatic flux_item_t rusanov_flux(face_item_t f);
        logic signed [127:0] hl, hr, ul, ur, vl, vr, g, sl, sr, s;
        logic signed [127:0] ql, qr, tl, tr, fm, fn, ft;
        flux_item_t o;
        logic sat;
        hl = f.hl; hr = f.hr; ul = f.ul; ur = f.ur; vl = f.vl; vr = f.vr;
        g = grav_model;
        sat = 0;
        if (f.mode == swrf_pkg::MODE_WALL_LEFT)
        begin
            hr = hl; ur = -ul; vr = vl;
        end
        else if (f.mode == swrf_pkg::MODE_WALL_RIGHT)
        begin
            hl = hr; ul = -ur; vl = vr;
        end
        sl = (ul < 0 ? -ul : ul) + int_sqrt(64'(g * hl));
        sr = (ur < 0 ? -ur : ur) + int_sqrt(64'(g * hr));
        s = sl > sr ? sl : sr;
        ql = fx_mul(hl, ul);
        qr = fx_mul(hr, ur);
        tl = fx_mul(hl, vl);
        tr = fx_mul(hr, vr);
        fm = halve_away(ql + qr - fx_mul(s, hr - hl));
        fn = halve_away(fx_mul(ql, ul) + halve_away(fx_mul(fx_mul(g, hl), hl))
                        + fx_mul(qr, ur) + halve_away(fx_mul(fx_mul(g, hr), hr))
                        - fx_mul(s, qr - ql));
        ft = halve_away(fx_mul(ql, vl) + fx_mul(qr, vr) - fx_mul(s, tr - tl));
        o.fm = clamp_flux(fm, sat);
        o.fn = clamp_flux(fn, sat);
        o.ft = clamp_flux(ft, sat);
        o.spd = s > 128'sh7fffffff ? 31'h7fffffff : s[30:0];
        o.sat = sat;
        return o;
    endfunction

    function automatic bit idle_now();
        return !calm && ($urandom_range(99) < 36);
    endfunction

    // Face driver: presents queued faces and predicts each accepted one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            face_ch.valid <= 1'b0;
            {face_ch.mode, face_ch.depth_left, face_ch.normal_vel_left,
             face_ch.tangent_vel_left, face_ch.depth_right,
             face_ch.normal_vel_right, face_ch.tangent_vel_right} <= '0;
            cfg_ch.valid <= 1'b0;
            cfg_ch.gravity <= '0;
        end
        else
        begin
            if (cfg_ch.valid && cfg_ch.ready)
                grav_model = cfg_ch.gravity;
            if (face_ch.valid && face_ch.ready)
                flux_expected.push_back(rusanov_flux(face_queue.pop_front()));
            if (cfg_ch.valid && !cfg_ch.ready)
                ;
            else if (grav_req)
            begin
                cfg_ch.valid <= 1'b1;
                cfg_ch.gravity <= grav_pending;
                grav_req = 0;
            end
            else
                cfg_ch.valid <= 1'b0;
            if (!(face_ch.valid && !face_ch.ready))
            begin
                if (face_queue.size() > 0 && !idle_now())
                begin
                    face_ch.valid <= 1'b1;
                    {face_ch.mode, face_ch.depth_left, face_ch.normal_vel_left,
                     face_ch.tangent_vel_left, face_ch.depth_right,
                     face_ch.normal_vel_right, face_ch.tangent_vel_right}
                        <= face_queue[0];
                end
                else
                    face_ch.valid <= 1'b0;
            end
        end
    end

    // Flux monitor: random stalls and in-order comparison.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            flux_ch.ready <= 1'b0;
        else
        begin
            if (flux_ch.valid && flux_ch.ready)
            begin
                flux_item_t got;
                flux_item_t want;
                got = {flux_ch.mass_flux, flux_ch.normal_mom_flux,
                       flux_ch.tangent_mom_flux, flux_ch.max_wave_speed,
                       flux_ch.saturated};
                if (flux_expected.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected flux transaction %h", got);
                end
                else
                begin
                    want = flux_expected.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("flux mismatch: exp m=%0d n=%0d t=%0d s=%0d c=%0b",
                                     want.fm, want.fn, want.ft, want.spd, want.sat,
                                     " got m=%0d n=%0d t=%0d s=%0d c=%0b",
                                     got.fm, got.fn, got.ft, got.spd, got.sat);
                    end
                end
            end
            flux_ch.ready <= !idle_now();
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [31:0] rand_vel();
        case ($urandom_range(5))
            0: return 32'h80000000;
            1: return 32'h7fffffff;
            2: return $urandom_range(32'h60000) - 32'h30000;
            3: return $urandom_range(32'h2000000) - 32'h1000000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [HW-1:0] rand_depth();
        case ($urandom_range(4))
            0: return $urandom_range(1) ? '1 : '0;
            1: return HW'($urandom_range(32'h80000));
            2: return HW'($urandom_range(32'h4000000));
            default: return HW'($urandom);
        endcase
    endfunction

    function automatic face_item_t rand_face();
        face_item_t f;
        f.mode = $urandom_range(9) == 0 ? 2'd3 : 2'($urandom_range(2));
        f.hl = rand_depth();
        f.ul = rand_vel();
        f.vl = rand_vel();
        f.hr = rand_depth();
        f.ur = rand_vel();
        f.vr = rand_vel();
        return f;
    endfunction

    // Waits until every expected flux is back and the pipeline has drained.
    task automatic settle();
        while (face_queue.size() > 0 || flux_expected.size() > 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic write_gravity(logic [GW-1:0] g);
        grav_pending = g;
        grav_req = 1;
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        logic [GW-1:0] gsets[5];
        face_item_t f;
        gsets = '{25'd0, 25'd16777216, 25'd1, 25'd642908, 25'd0};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed faces: extremes, every mode, most negative mirrored velocity.
        for (int m = 0; m < 4; m++)
        begin
            face_queue.push_back({2'(m), 31'h0, 32'h0, 32'h0, 31'h0, 32'h0, 32'h0});
            face_queue.push_back({2'(m), 31'h7fffffff, 32'h80000000, 32'h7fffffff,
                                  31'h7fffffff, 32'h80000000, 32'h80000000});
            face_queue.push_back({2'(m), 31'h10000, 32'h7fffffff, 32'h80000000,
                                  31'h20000, 32'h7fffffff, 32'h7fffffff});
            face_queue.push_back({2'(m), 31'h18000, 32'h8000, 32'hffff8000,
                                  31'h8000, 32'hfffe0000, 32'h30000});
        end
        settle();

        // Random phases under several gravity settings, one without idling.
        for (int p = 0; p < 5; p++)
        begin
            write_gravity(p == 4 ? 25'($urandom_range(25'h1ffffff)) : gsets[p]);
            calm = (p == 2);
            for (int i = 0; i < 190; i++)
            begin
                f = rand_face();
                face_queue.push_back(f);
            end
            settle();
            calm = 0;
        end

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
